[sv/stb_pkg.sv]
// ----------------------------------------------------------------------------
// Software timer bank package
// Shared constants, codes and request, result and control types.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = $clog2(NUM_TIMERS);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t T_NEVER    = '1;
  localparam count_t T_INFINITE = T_NEVER - count_t'(1);

  localparam logic [1:0] ACT_ARM    = 2'd0;
  localparam logic [1:0] ACT_DISARM = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  localparam logic [2:0] K_ARMED    = 3'd0;
  localparam logic [2:0] K_DISARMED = 3'd1;
  localparam logic [2:0] K_EXPIRED  = 3'd2;
  localparam logic [2:0] K_NONE     = 3'd3;
  localparam logic [2:0] K_ERROR    = 3'd4;
  localparam logic [2:0] K_QUERY    = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  timer_id;
    logic [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  which_timer;
    logic [31:0] overshoot;
    logic        is_armed;
    logic        last;
  } res_t;

  typedef struct packed {
    logic   shift;
    logic   wr;
    count_t wr_value;
  } cell_ctl_t;

  typedef struct packed {
    logic        expire;
    count_t      next_count;
    logic [31:0] overshoot;
  } head_t;

endpackage

[sv/software_timer_bank.sv]
// ----------------------------------------------------------------------------
// Software timer bank
// Sixteen one-shot timers held in a ring of cells with one tick unit.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------
//   request  | start, busy           | request (req_t)
//   result   | result_valid (strobe) | result (res_t)
//
// Arm, disarm and query answer in the cycle after acceptance and may follow
// back to back. A tick rotates the ring once, one timer per cycle through
// the tick unit, then flushes the final result; the bank stays busy and
// takes no request until the flush is done. Reset disarms every timer at once.
// Results are never stalled; each strobe lasts one cycle.
// ----------------------------------------------------------------------------
module software_timer_bank import stb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic result_valid,
  output res_t result
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_TICK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t      state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [31:0] delta, delta_next;
  logic        pend, pend_next;
  res_t        pend_res, pend_res_next;
  logic        result_valid_next;
  res_t        result_next;

  cell_ctl_t   ctl [NUM_TIMERS];
  count_t      cell_val [NUM_TIMERS];
  head_t       head;

  logic        accept;
  logic        id_ok;
  count_t      sel;
  count_t      arm_value;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign id_ok  = (32'(request.timer_id) < NUM_TIMERS);
  assign sel    = cell_val[IDX_W'(request.timer_id)];
  assign arm_value = (count_t'(request.amount) > T_INFINITE) ?
                     T_INFINITE : count_t'(request.amount);

  genvar g;
  generate
    for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
      count_t sin;
      if (g == NUM_TIMERS - 1) begin : g_tail
        assign sin = head.next_count;
      end else begin : g_body
        assign sin = cell_val[g+1];
      end
      stb_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl[g]),
        .shift_in (sin),
        .value    (cell_val[g])
      );
    end
  endgenerate

  stb_head u_head (
    .count (cell_val[0]),
    .delta (delta),
    .res   (head)
  );

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    delta_next        = delta;
    pend_next         = pend;
    pend_res_next     = pend_res;
    result_valid_next = 1'b0;
    result_next       = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      ctl[i] = '{shift: 1'b0, wr: 1'b0, wr_value: T_NEVER};
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          result_next.which_timer = request.timer_id;
          result_next.last        = 1'b1;
          unique case (request.action)
            ACT_ARM: begin
              result_valid_next = 1'b1;
              if (id_ok && sel == T_NEVER) begin
                result_next.kind = K_ARMED;
                ctl[IDX_W'(request.timer_id)].wr       = 1'b1;
                ctl[IDX_W'(request.timer_id)].wr_value = arm_value;
              end else begin
                result_next.kind = K_ERROR;
              end
            end
            ACT_DISARM: begin
              result_valid_next = 1'b1;
              result_next.kind  = K_DISARMED;
              if (id_ok) begin
                ctl[IDX_W'(request.timer_id)].wr = 1'b1;
              end
            end
            ACT_QUERY: begin
              result_valid_next    = 1'b1;
              result_next.kind     = K_QUERY;
              result_next.is_armed = id_ok && (sel != T_NEVER);
            end
            ACT_TICK: begin
              result_next = '0;
              delta_next  = request.amount;
              cnt_next    = '0;
              pend_next   = 1'b0;
              state_next  = ST_TICK;
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          ctl[i].shift = 1'b1;
        end
        if (head.expire) begin
          if (pend) begin
            result_valid_next = 1'b1;
            result_next       = pend_res;
          end
          pend_next                 = 1'b1;
          pend_res_next.kind        = K_EXPIRED;
          pend_res_next.which_timer = 4'(cnt);
          pend_res_next.overshoot   = head.overshoot;
          pend_res_next.is_armed    = 1'b0;
          pend_res_next.last        = 1'b0;
        end
        cnt_next = cnt + IDX_W'(1);
        if (cnt == IDX_W'(NUM_TIMERS - 1)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        result_valid_next = 1'b1;
        if (pend) begin
          result_next = pend_res;
        end else begin
          result_next.kind = K_NONE;
        end
        result_next.last = 1'b1;
        pend_next        = 1'b0;
        state_next       = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      pend         <= pend_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    delta    <= delta_next;
    pend_res <= pend_res_next;
    result   <= result_next;
  end

  a_cmd_answers: assert property (@(posedge clk) disable iff (rst)
    (accept && request.action != ACT_TICK) |=> (result_valid && result.last && !busy))
    else $error("command did not answer in the next cycle");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && request.action == ACT_TICK) |=> (busy && !result_valid))
    else $error("tick did not start a walk");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |=> (result_valid && result.last && !busy))
    else $error("tick walk did not close with a final result");

  a_armed_query: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.is_armed) |-> (result.kind == K_QUERY))
    else $error("armed flag set outside a query answer");

endmodule

[sv/stb_cell.sv]
// ----------------------------------------------------------------------------
// Timer cell
// Holds one remaining count; loads from its neighbor on a shift or takes a
// direct write.
// ----------------------------------------------------------------------------
module stb_cell import stb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  count_t    shift_in,
  output count_t    value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= T_NEVER;
    end else if (ctl.shift) begin
      value <= shift_in;
    end else if (ctl.wr) begin
      value <= ctl.wr_value;
    end
  end

endmodule

[sv/stb_head.sv]
// ----------------------------------------------------------------------------
// Tick head unit
// Applies an elapsed delta to the count leaving the front of the ring.
// ----------------------------------------------------------------------------
module stb_head import stb_pkg::*; (
  input  count_t      count,
  input  logic [31:0] delta,
  output head_t       res
);

  count_t d;

  assign d = count_t'(delta);

  always_comb begin
    res.expire     = 1'b0;
    res.next_count = count;
    res.overshoot  = '0;
    if (count != T_NEVER) begin
      if (count <= d) begin
        res.expire     = 1'b1;
        res.next_count = T_NEVER;
        res.overshoot  = 32'(d - count);
      end else if (count < T_INFINITE) begin
        res.next_count = count - d;
      end
    end
  end

endmodule
